/* src/ctii_pkg.sv */
// ----------------------------------------------------------------------------
// ctii_pkg
// Shared widths, codes and helpers of the calibration table interpolator.
// ----------------------------------------------------------------------------
package ctii_pkg;

	localparam int CMD_W   = 2;
	localparam int POS_W   = 21;
	localparam int VOLT_W  = 25;
	localparam int STAT_W  = 2;
	localparam int CNT_W   = 7;
	localparam int DP_W    = POS_W + 1;          // key/position difference
	localparam int DV_W    = VOLT_W + 1;         // voltage difference
	localparam int PROD_W  = DP_W + DV_W;        // signed product
	localparam int MAG_W   = PROD_W - 1;         // product magnitude
	localparam int SUM_W   = PROD_W + 2;         // v_lo + quotient

	localparam logic signed [SUM_W-1:0] VOLT_LIM = SUM_W'(10000000);

	typedef logic [CMD_W-1:0]         cmd_t;
	typedef logic signed [POS_W-1:0]  pos_t;
	typedef logic signed [VOLT_W-1:0] volt_t;
	typedef logic [STAT_W-1:0]        stat_t;
	typedef logic [CNT_W-1:0]         cnt_t;

	localparam cmd_t CMD_QUERY   = 2'd0;
	localparam cmd_t CMD_RESTART = 2'd1;
	localparam cmd_t CMD_APPEND  = 2'd2;

	localparam stat_t STAT_OK     = 2'd0;
	localparam stat_t STAT_REJECT = 2'd1;
	localparam stat_t STAT_SAT    = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EVAL,
		ST_MUL,
		ST_DIVS,
		ST_DIV,
		ST_FIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		volt_t volt;
		stat_t stat;
	} sat_t;

	function automatic sat_t saturate(input logic signed [SUM_W-1:0] x);
		sat_t r;
		if (x > VOLT_LIM) begin
			r.volt = VOLT_W'(VOLT_LIM);
			r.stat = STAT_SAT;
		end else if (x < -VOLT_LIM) begin
			r.volt = VOLT_W'(-VOLT_LIM);
			r.stat = STAT_SAT;
		end else begin
			r.volt = VOLT_W'(x);
			r.stat = STAT_OK;
		end
		return r;
	endfunction

endpackage

/* src/ctii_req_if.sv */
// ----------------------------------------------------------------------------
// ctii_req_if
// Request channel: command, position and entry voltage.
// ----------------------------------------------------------------------------
interface ctii_req_if;
	logic            valid;
	logic            ready;
	ctii_pkg::cmd_t  cmd;
	ctii_pkg::pos_t  position;
	ctii_pkg::volt_t entry_voltage;

	modport source (output valid, cmd, position, entry_voltage, input ready);
	modport sink   (input valid, cmd, position, entry_voltage, output ready);
endinterface

/* src/ctii_rsp_if.sv */
// ----------------------------------------------------------------------------
// ctii_rsp_if
// Response channel: voltage, status and entry count.
// ----------------------------------------------------------------------------
interface ctii_rsp_if;
	logic            valid;
	logic            ready;
	ctii_pkg::volt_t voltage;
	ctii_pkg::stat_t status;
	ctii_pkg::cnt_t  entry_count;

	modport source (output valid, voltage, status, entry_count, input ready);
	modport sink   (input valid, voltage, status, entry_count, output ready);
endinterface

/* src/calibration_table_interpolator_unit.sv */
// ----------------------------------------------------------------------------
// calibration_table_interpolator_unit
// Piecewise linear calibration lookup over a rotating chain of table cells.
// ----------------------------------------------------------------------------
// Usage:
//  req carries one item: cmd (query / restart table / append entry), a
//  position in 0.01 um and, for loads, an entry voltage in uV. rsp returns
//  one item per request: voltage (zero for loads), status and entry count.
//  The table lives in a ring of TABLE_DEPTH cells. Every item rotates the
//  ring once; the entry passing cell 0 is inspected, and a load substitutes
//  its entry there as the ring closes.
//  Loads, exact hits and clamped queries finish after the ring walk;
//  interpolated queries add a multiply, a bit-serial divide and the final add.
//  The ring walk and the divider set the rate; one item is in work at once,
//  req.ready is high only in idle.
//  Reset: the table holds a single entry (0, 0). Entry 0 reads as zero
//  until the first rotation writes it back.
//  A finished item sits in the rsp register; while rsp is stalled the next
//  item can be accepted and worked on, and it waits until the register frees.
// ----------------------------------------------------------------------------
module calibration_table_interpolator_unit #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	ctii_req_if.sink   req,
	ctii_rsp_if.source rsp
);
	import ctii_pkg::*;

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int NW = $clog2(TABLE_DEPTH + 1);

	state_t state_q, state_d;

	// item context
	cmd_t  cmd_q;
	pos_t  pos_q;
	volt_t ev_q;

	// ring control
	logic [IW-1:0] j_q;
	logic [NW-1:0] n_q;
	logic          init_q;
	logic          scan_end;
	logic          in_range;
	logic          write_now;

	// ring wiring
	pos_t  key_w  [TABLE_DEPTH];
	volt_t volt_w [TABLE_DEPTH];
	pos_t  head_key,  tail_key;
	volt_t head_volt, tail_volt;

	// scan results
	pos_t  k0_q, prevk_q, lastk_q, klo_q, khi_q;
	volt_t v0_q, prevv_q, vlo_q, vhi_q, mv_q;
	logic  match_q, found_q, appended_q;

	// arithmetic
	logic signed [PROD_W-1:0] prod_q;
	logic signed [DP_W-1:0]   dk_q;
	logic                     neg_q;
	logic [MAG_W-1:0]         quo;
	logic                     div_done;
	logic                     div_start;
	logic signed [DP_W-1:0]   dk_c;
	logic [MAG_W-1:0]         num_mag;
	logic [DP_W-1:0]          den_mag;
	logic signed [SUM_W-1:0]  sum_c;
	sat_t                     sat_c;
	sat_t                     sat_e;

	// result and output register
	volt_t res_volt_q;
	stat_t res_stat_q;
	logic  out_valid_q;
	volt_t out_volt_q;
	stat_t out_stat_q;
	cnt_t  out_cnt_q;
	logic  out_free;

	// ------------------------------------------------------------------ ring
	assign head_key  = (j_q == '0 && !init_q) ? '0 : key_w[0];
	assign head_volt = (j_q == '0 && !init_q) ? '0 : volt_w[0];
	assign in_range  = NW'(j_q) < n_q;
	assign scan_end  = j_q == IW'(TABLE_DEPTH - 1);

	// restart lands on entry 0, an append just past the last entry
	assign write_now = (state_q == ST_SCAN) &&
		(((cmd_q == CMD_RESTART) && (j_q == '0)) ||
		 ((cmd_q == CMD_APPEND) && (NW'(j_q) == n_q) && (pos_q > lastk_q)));

	assign tail_key  = write_now ? pos_q : head_key;
	assign tail_volt = write_now ? ev_q  : head_volt;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		if (i == TABLE_DEPTH - 1) begin : g_tail
			ctii_cell u_cell (
				.clk    (clk),
				.shift  (state_q == ST_SCAN),
				.d_key  (tail_key),
				.d_volt (tail_volt),
				.q_key  (key_w[i]),
				.q_volt (volt_w[i])
			);
		end else begin : g_mid
			ctii_cell u_cell (
				.clk    (clk),
				.shift  (state_q == ST_SCAN),
				.d_key  (key_w[i+1]),
				.d_volt (volt_w[i+1]),
				.q_key  (key_w[i]),
				.q_volt (volt_w[i])
			);
		end
	end

	// ---------------------------------------------------------- arithmetic
	assign dk_c    = (dk_q == '0) ? DP_W'(1) : dk_q;
	assign num_mag = prod_q[PROD_W-1] ? MAG_W'(-prod_q) : MAG_W'(prod_q);
	assign den_mag = dk_c[DP_W-1] ? DP_W'(-dk_c) : DP_W'(dk_c);
	assign div_start = state_q == ST_DIVS;

	ctii_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_mag),
		.den    (den_mag),
		.quo    (quo),
		.done   (div_done)
	);

	// truncation toward zero: apply the sign to the magnitude quotient
	assign sum_c = SUM_W'(vlo_q) +
		(neg_q ? -SUM_W'({1'b0, quo}) : SUM_W'({1'b0, quo}));
	assign sat_c = saturate(sum_c);

	// exact hit or clamp to the first entry
	assign sat_e = saturate(SUM_W'(match_q ? mv_q : v0_q));

	assign out_free = !out_valid_q || rsp.ready;

	// --------------------------------------------------------------- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_end) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (cmd_q == CMD_QUERY && !match_q && n_q >= NW'(2) && !(pos_q < k0_q))
					state_d = ST_MUL;
				else
					state_d = ST_DONE;
			end
			ST_MUL:  state_d = ST_DIVS;
			ST_DIVS: state_d = ST_DIV;
			ST_DIV: begin
				if (div_done) state_d = ST_FIN;
			end
			ST_FIN:  state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q         <= '0;
			n_q         <= NW'(1);
			init_q      <= 1'b0;
			match_q     <= 1'b0;
			found_q     <= 1'b0;
			appended_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_IDLE && req.valid) begin
				j_q        <= '0;
				match_q    <= 1'b0;
				found_q    <= 1'b0;
				appended_q <= 1'b0;
			end
			if (state_q == ST_SCAN) begin
				j_q    <= j_q + 1'b1;
				init_q <= 1'b1;
				if (in_range && head_key == pos_q) match_q <= 1'b1;
				if (in_range && j_q != '0 && !found_q &&
				    (head_key > pos_q || NW'(j_q) == n_q - 1'b1))
					found_q <= 1'b1;
				if (write_now && cmd_q == CMD_APPEND) appended_q <= 1'b1;
			end
			if (state_q == ST_EVAL) begin
				if (cmd_q == CMD_RESTART) n_q <= NW'(1);
				else if (appended_q)     n_q <= n_q + 1'b1;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// --------------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			cmd_q <= req.cmd;
			pos_q <= req.position;
			ev_q  <= req.entry_voltage;
		end
		if (state_q == ST_SCAN) begin
			prevk_q <= head_key;
			prevv_q <= head_volt;
			if (j_q == '0) begin
				k0_q <= head_key;
				v0_q <= head_volt;
			end
			if (in_range && NW'(j_q) == n_q - 1'b1) lastk_q <= head_key;
			if (in_range && head_key == pos_q) mv_q <= head_volt;
			if (in_range && j_q != '0 && !found_q &&
			    (head_key > pos_q || NW'(j_q) == n_q - 1'b1)) begin
				klo_q <= prevk_q;
				vlo_q <= prevv_q;
				khi_q <= head_key;
				vhi_q <= head_volt;
			end
		end
		if (state_q == ST_EVAL) begin
			res_volt_q <= '0;
			res_stat_q <= STAT_OK;
			if (cmd_q == CMD_APPEND && !appended_q) begin
				res_stat_q <= STAT_REJECT;
			end else if (cmd_q == CMD_QUERY) begin
				res_volt_q <= sat_e.volt;
				res_stat_q <= sat_e.stat;
			end
		end
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(DV_W'(vhi_q) - DV_W'(vlo_q)) *
			          PROD_W'(DP_W'(pos_q) - DP_W'(klo_q));
			dk_q   <= DP_W'(khi_q) - DP_W'(klo_q);
		end
		if (state_q == ST_DIVS) begin
			neg_q <= prod_q[PROD_W-1] ^ dk_c[DP_W-1];
		end
		if (state_q == ST_FIN) begin
			res_volt_q <= sat_c.volt;
			res_stat_q <= sat_c.stat;
		end
		if (state_q == ST_DONE && out_free) begin
			out_volt_q <= res_volt_q;
			out_stat_q <= res_stat_q;
			out_cnt_q  <= CNT_W'(n_q);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.voltage     = out_volt_q;
	assign rsp.status      = out_stat_q;
	assign rsp.entry_count = out_cnt_q;
endmodule

/* src/ctii_cell.sv */
// ----------------------------------------------------------------------------
// ctii_cell
// One table entry of the rotating chain; takes its neighbor's entry on shift.
// ----------------------------------------------------------------------------
module ctii_cell (
	input  logic            clk,
	input  logic            shift,
	input  ctii_pkg::pos_t  d_key,
	input  ctii_pkg::volt_t d_volt,
	output ctii_pkg::pos_t  q_key,
	output ctii_pkg::volt_t q_volt
);
	import ctii_pkg::*;

	pos_t  key_q;
	volt_t volt_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			key_q  <= d_key;
			volt_q <= d_volt;
		end
	end

	assign q_key  = key_q;
	assign q_volt = volt_q;
endmodule

/* src/ctii_div.sv */
// ----------------------------------------------------------------------------
// ctii_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ctii_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ctii_pkg::MAG_W-1:0]   num,
	input  logic [ctii_pkg::DP_W-1:0]    den,
	output logic [ctii_pkg::MAG_W-1:0]   quo,
	output logic                         done
);
	import ctii_pkg::*;

	localparam int CW = $clog2(MAG_W + 1);

	logic [DP_W:0]    rem_q;
	logic [MAG_W-1:0] quo_q;
	logic [DP_W-1:0]  den_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DP_W:0]    rem_sh;
	logic             ge;

	assign rem_sh = {rem_q[DP_W-1:0], quo_q[MAG_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(MAG_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
			quo_q <= {quo_q[MAG_W-2:0], ge};
		end
	end

	assign quo  = quo_q;
	assign done = done_q;
endmodule
